// ===== src/elfhc_pkg.sv =====
// Shared types and constants of the executable image header checker.
package elfhc_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_IMAGE_SIZE  = 2'd0;
   localparam logic [1:0] CSR_WINDOW_LOW  = 2'd1;
   localparam logic [1:0] CSR_WINDOW_HIGH = 2'd2;

   // Item kinds.
   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_ENTRY  = 1'b1;

   // Fixed header and entry values.
   localparam logic [31:0] IMG_MAGIC      = 32'h464C_457F;
   localparam logic [31:0] MIN_IMAGE_SIZE = 32'd20;
   localparam logic [7:0]  IDENT_CLASS32  = 8'd1;
   localparam logic [7:0]  IDENT_LITTLE   = 8'd1;
   localparam logic [15:0] KIND_EXEC      = 16'd2;
   localparam logic [15:0] MACHINE_ID     = 16'd3;
   localparam logic [15:0] MIN_ENTRY_SIZE = 16'd32;
   localparam logic [31:0] SEG_LOADABLE   = 32'd1;
   localparam logic [31:0] PAGE_MASK      = 32'h0000_0FFF;
   localparam logic [31:0] NO_SEG         = 32'hFFFF_FFFF;

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_NOTIMAGE = 4'd1,
      ST_CLASS    = 4'd2,
      ST_ORDER    = 4'd3,
      ST_KIND     = 4'd4,
      ST_MACHINE  = 4'd5,
      ST_COUNT    = 4'd6,
      ST_ENTSIZE  = 4'd7,
      ST_TABLE    = 4'd8,
      ST_SEGFILE  = 4'd9,
      ST_FILEMEM  = 4'd10,
      ST_WINDOW   = 4'd11,
      ST_NOLOAD   = 4'd12,
      ST_ENTRY    = 4'd13
   } status_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] magic_or_seg_type;
      logic [7:0]  ident_class;
      logic [7:0]  ident_order;
      logic [15:0] file_kind;
      logic [15:0] machine_code;
      logic [31:0] entry_or_seg_vaddr;
      logic [31:0] table_or_seg_offset;
      logic [15:0] entry_size;
      logic [15:0] entry_count;
      logic [31:0] seg_file_bytes;
      logic [31:0] seg_mem_bytes;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] entry_address;
      logic [31:0] image_low;
      logic [31:0] image_span;
   } rsp_type;

endpackage

// ===== src/elf_image_header_check.sv =====
// Top level of the executable image header checker.
//
// The block takes one item per cycle: a file header item starts a table walk,
// and each program header entry item that follows is checked as it arrives.
// An accepted item is captured in an input register, together with the
// header's table size (entry count times entry size), which is multiplied out
// before that register. Once the result register is free or being emptied, all
// checks and the span update run from the input register. When the item causes
// a result, the result register is loaded at the next edge and drives the
// result port. A new item is taken in every cycle as long as the result side
// keeps up. The input stalls whenever an item sits in the input register while
// a result waits in the result register under a stall, whether or not that
// item would report. A header reports only when it fails; an entry reports the
// first failure of its table, and the last entry of a clean table reports the
// final status, with the entry address, the page-aligned low address and the
// span on success. Configuration registers are read at the moment each item is
// processed, so they must be written only while the block is idle.
module elf_image_header_check #(
   parameter int MAX_SEGMENTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // Configuration write port.
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data,
   // Input items.
   input  logic                 req_valid,
   output logic                 req_stall,
   input  elfhc_pkg::req_type   req_data,
   // Result items.
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output elfhc_pkg::rsp_type   rsp_data
);

   // Width of the entry countdown, enough to hold MAX_SEGMENTS itself.
   localparam int CntW = $clog2(MAX_SEGMENTS + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WALK,
      PH_ABSORB
   } phase_type;

   // Configuration registers.
   logic [31:0] image_size_ff, window_low_ff, window_high_ff;

   // Input register stage.
   logic                s1_valid_ff, s1_valid_in;
   elfhc_pkg::req_type  s1_data_ff;
   logic [31:0]         s1_prod_ff;

   // Walk state.
   phase_type           phase_ff, phase_in;
   logic [CntW-1:0]     left_ff, left_in;
   logic [31:0]         span_low_ff, span_low_in;
   logic [31:0]         span_high_ff, span_high_in;
   logic [31:0]         saved_entry_ff, saved_entry_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   elfhc_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic out_free, advance, accept;

   // The processing stage may move on whenever the result register is empty
   // or its item is being taken in this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   // Header checks, in priority order.
   logic [31:0]          hdr_end;
   elfhc_pkg::status_type hdr_status;

   always_comb begin
      hdr_end = s1_data_ff.table_or_seg_offset + s1_prod_ff;
      if (image_size_ff < elfhc_pkg::MIN_IMAGE_SIZE ||
          s1_data_ff.magic_or_seg_type != elfhc_pkg::IMG_MAGIC) begin
         hdr_status = elfhc_pkg::ST_NOTIMAGE;
      end else if (s1_data_ff.ident_class != elfhc_pkg::IDENT_CLASS32) begin
         hdr_status = elfhc_pkg::ST_CLASS;
      end else if (s1_data_ff.ident_order != elfhc_pkg::IDENT_LITTLE) begin
         hdr_status = elfhc_pkg::ST_ORDER;
      end else if (s1_data_ff.file_kind != elfhc_pkg::KIND_EXEC) begin
         hdr_status = elfhc_pkg::ST_KIND;
      end else if (s1_data_ff.machine_code != elfhc_pkg::MACHINE_ID) begin
         hdr_status = elfhc_pkg::ST_MACHINE;
      end else if (s1_data_ff.entry_count == 16'd0 ||
                   {1'b0, s1_data_ff.entry_count} > 17'(MAX_SEGMENTS)) begin
         hdr_status = elfhc_pkg::ST_COUNT;
      end else if (s1_data_ff.entry_size < elfhc_pkg::MIN_ENTRY_SIZE) begin
         hdr_status = elfhc_pkg::ST_ENTSIZE;
      end else if (s1_data_ff.table_or_seg_offset >= image_size_ff ||
                   hdr_end > image_size_ff ||
                   hdr_end < s1_data_ff.table_or_seg_offset) begin
         hdr_status = elfhc_pkg::ST_TABLE;
      end else begin
         hdr_status = elfhc_pkg::ST_OK;
      end
   end

   // Entry checks. The page-rounded end wraps before the low bits are cleared.
   logic                  seg_used;
   logic [31:0]           seg_lo, seg_hi;
   elfhc_pkg::status_type seg_status;

   always_comb begin
      seg_used = (s1_data_ff.magic_or_seg_type == elfhc_pkg::SEG_LOADABLE) &&
                 (s1_data_ff.seg_mem_bytes != 32'd0);
      seg_lo = s1_data_ff.entry_or_seg_vaddr & ~elfhc_pkg::PAGE_MASK;
      seg_hi = (s1_data_ff.entry_or_seg_vaddr + s1_data_ff.seg_mem_bytes +
                elfhc_pkg::PAGE_MASK) & ~elfhc_pkg::PAGE_MASK;
      if (!seg_used) begin
         seg_status = elfhc_pkg::ST_OK;
      end else if (s1_data_ff.table_or_seg_offset >= image_size_ff ||
                   s1_data_ff.seg_file_bytes >
                   (image_size_ff - s1_data_ff.table_or_seg_offset)) begin
         seg_status = elfhc_pkg::ST_SEGFILE;
      end else if (s1_data_ff.seg_file_bytes > s1_data_ff.seg_mem_bytes) begin
         seg_status = elfhc_pkg::ST_FILEMEM;
      end else if (seg_lo < window_low_ff || seg_hi > window_high_ff) begin
         seg_status = elfhc_pkg::ST_WINDOW;
      end else begin
         seg_status = elfhc_pkg::ST_OK;
      end
   end

   // Next state and result of the item in the processing stage.
   logic [CntW-1:0] left_dec;
   logic            emit;

   always_comb begin
      phase_in       = phase_ff;
      left_in        = left_ff;
      span_low_in    = span_low_ff;
      span_high_in   = span_high_ff;
      saved_entry_in = saved_entry_ff;
      emit           = 1'b0;
      rsp_data_in    = '{status: elfhc_pkg::ST_OK, entry_address: 32'd0,
                         image_low: 32'd0, image_span: 32'd0};
      left_dec       = (left_ff != '0) ? left_ff - CntW'(1) : left_ff;

      if (advance) begin
         if (s1_data_ff.opcode == elfhc_pkg::OP_HEADER) begin
            // A header always restarts; an unfinished walk is dropped.
            if (hdr_status != elfhc_pkg::ST_OK) begin
               phase_in           = PH_IDLE;
               left_in            = '0;
               emit               = 1'b1;
               rsp_data_in.status = hdr_status;
            end else begin
               phase_in       = PH_WALK;
               left_in        = CntW'(s1_data_ff.entry_count);
               span_low_in    = elfhc_pkg::NO_SEG;
               span_high_in   = 32'd0;
               saved_entry_in = s1_data_ff.entry_or_seg_vaddr;
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  // Entries with no table in progress are dropped.
               end
               PH_ABSORB: begin
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_WALK: begin
                  left_in = left_dec;
                  if (seg_status != elfhc_pkg::ST_OK) begin
                     phase_in           = (left_dec == '0) ? PH_IDLE : PH_ABSORB;
                     emit               = 1'b1;
                     rsp_data_in.status = seg_status;
                  end else begin
                     if (seg_used && seg_lo < span_low_ff) begin
                        span_low_in = seg_lo;
                     end
                     if (seg_used && seg_hi > span_high_ff) begin
                        span_high_in = seg_hi;
                     end
                     if (left_dec == '0) begin
                        // Last entry of a clean table: final report.
                        phase_in = PH_IDLE;
                        emit     = 1'b1;
                        if (span_low_in == elfhc_pkg::NO_SEG) begin
                           rsp_data_in.status = elfhc_pkg::ST_NOLOAD;
                        end else if (saved_entry_ff < window_low_ff ||
                                     saved_entry_ff >= window_high_ff) begin
                           rsp_data_in.status = elfhc_pkg::ST_ENTRY;
                        end else begin
                           rsp_data_in.entry_address = saved_entry_ff;
                           rsp_data_in.image_low     = span_low_in;
                           rsp_data_in.image_span    = span_high_in - span_low_in;
                        end
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff  <= 32'd0;
         window_low_ff  <= 32'd0;
         window_high_ff <= 32'hFFFF_FFFF;
         s1_valid_ff    <= 1'b0;
         phase_ff       <= PH_IDLE;
         left_ff        <= '0;
         span_low_ff    <= elfhc_pkg::NO_SEG;
         span_high_ff   <= 32'd0;
         saved_entry_ff <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               elfhc_pkg::CSR_IMAGE_SIZE:  image_size_ff  <= csr_data;
               elfhc_pkg::CSR_WINDOW_LOW:  window_low_ff  <= csr_data;
               elfhc_pkg::CSR_WINDOW_HIGH: window_high_ff <= csr_data;
               default: begin
               end
            endcase
         end
         s1_valid_ff    <= s1_valid_in;
         phase_ff       <= phase_in;
         left_ff        <= left_in;
         span_low_ff    <= span_low_in;
         span_high_ff   <= span_high_in;
         saved_entry_ff <= saved_entry_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_data;
         s1_prod_ff <= 32'(req_data.entry_count) * 32'(req_data.entry_size);
      end
      if (advance && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A table walk is in progress exactly while entries remain to be seen.
   a_phase_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) == (left_ff == '0))
      else $error("phase and entry countdown disagree");

   // The input is held back only while the processing stage is occupied.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled without a waiting item");

   // Error results carry zero address fields.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != elfhc_pkg::ST_OK |->
      rsp_data_ff.entry_address == 32'd0 && rsp_data_ff.image_low == 32'd0 &&
      rsp_data_ff.image_span == 32'd0)
      else $error("error result with nonzero payload");

   // A successful image always starts on a page boundary.
   a_ok_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == elfhc_pkg::ST_OK |->
      (rsp_data_ff.image_low & elfhc_pkg::PAGE_MASK) == 32'd0)
      else $error("image low address not page aligned");

endmodule
